>>> rtl/olst_pkg.sv
// Shared types and constants for the ordered list store.
package olst_pkg;

   // Default sizing of the list
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed port widths
   localparam int WORD_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_POP    = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_FIND   = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_PULL,
      CELL_FIND,
      CELL_REMOVE
   } cell_op_type;

endpackage

>>> rtl/olst_cell.sv
// One storage cell of the list chain: an entry, its compare and the match carry.
module olst_cell #(
   parameter int VALUE_WIDTH = olst_pkg::VALUE_WIDTH_DEF,
   parameter int CNT_W       = 5,
   parameter int IDX_W       = 4,
   parameter int INDEX       = 0
) (
   input  logic                     clock,
   input  olst_pkg::cell_op_type    op_i,
   input  logic [VALUE_WIDTH-1:0]   value_i,
   input  logic [CNT_W-1:0]         count_i,
   input  logic [IDX_W-1:0]         step_i,
   input  logic [VALUE_WIDTH-1:0]   prev_entry_i,
   input  logic [VALUE_WIDTH-1:0]   next_entry_i,
   input  logic                     carry_i,
   output logic [VALUE_WIDTH-1:0]   entry_o,
   output logic                     carry_o
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   carry_ff;
   logic                   carry_in;
   logic                   active;
   logic                   occupied;
   logic                   chain;

   // Compare against the broadcast value while the scan wave sits here
   always_comb begin
      active   = (step_i == IDX_W'(INDEX));
      occupied = (CNT_W'(INDEX) < count_i);
      chain    = carry_i || (occupied && (entry_ff == value_i));
   end

   // Select the next entry: shift back, shift forward or close the gap
   always_comb begin
      entry_in = entry_ff;
      carry_in = carry_ff;
      case (op_i)
         olst_pkg::CELL_PUSH: begin
            entry_in = prev_entry_i;
         end
         olst_pkg::CELL_PULL: begin
            entry_in = next_entry_i;
         end
         olst_pkg::CELL_FIND: begin
            if (active) begin
               carry_in = chain;
            end
         end
         olst_pkg::CELL_REMOVE: begin
            if (active) begin
               carry_in = chain;
               if (chain) begin
                  entry_in = next_entry_i;
               end
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign entry_o = entry_ff;
   assign carry_o = carry_ff;

endmodule

>>> rtl/ordered_list_store.sv
// Top level of the ordered list store: request control and the chain of cells.
//
// A bounded list of words, head first. Each request beat on req_ carries an
// action (insert at head, pop head, remove first match, find, clear) and a
// value; each produces exactly one result beat on rsp_ with a status, the
// popped word (zero otherwise) and the entry count after the request.
// Both channels use valid/ready; a request is taken only when the control is
// idle and the result register is empty or being emptied in the same cycle.
// Insert and pop shift the whole chain by one cell (not a full insert or
// an empty pop) and the result register loads at the same edge; clear
// zeroes the count without a shift. Find and remove send a scan wave down
// the chain, one cell per cycle; the length of the chain sets how long it
// runs. The gap of a removed entry closes as the wave passes.
// Requests can follow one per cycle after any action but find and remove
// while the receiver keeps up; after a find or remove the next request is
// taken only once the scan is over and its result has loaded.
// Reset empties the list (count zero) and drops any pending result; entry
// contents are not cleared and are never read before being written.
// When the receiver stalls, the result is held in the output register and
// no further request is taken until it has gone.
module ordered_list_store #(
   parameter int CAPACITY    = olst_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = olst_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [olst_pkg::ACTION_W-1:0] req_action,
   input  logic [olst_pkg::WORD_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [olst_pkg::STATUS_W-1:0] rsp_status,
   output logic [olst_pkg::WORD_W-1:0]   rsp_data,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int EXT_W = VALUE_WIDTH + olst_pkg::WORD_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              step_ff, step_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [VALUE_WIDTH-1:0]        value_ff, value_in;
   logic                          remove_ff, remove_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   olst_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [olst_pkg::WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;

   olst_pkg::cell_op_type         cell_op;
   logic                          rsp_free;
   logic                          accept;
   logic                          rsp_load;
   logic                          found;
   logic [EXT_W-1:0]              req_ext;
   logic [VALUE_WIDTH-1:0]        req_entry;
   logic [EXT_W-1:0]              head_ext;
   logic [olst_pkg::WORD_W-1:0]   head_word;

   logic [VALUE_WIDTH-1:0]        entry_w [CAPACITY];
   logic [VALUE_WIDTH-1:0]        prev_w  [CAPACITY];
   logic [VALUE_WIDTH-1:0]        next_w  [CAPACITY];
   logic                          carry_w [CAPACITY];
   logic                          carry_prev_w [CAPACITY];

   // Fit the request word to the entry width and the head to the port width
   assign req_ext   = EXT_W'(req_value);
   assign req_entry = req_ext[VALUE_WIDTH-1:0];
   assign head_ext  = EXT_W'(entry_w[0]);
   assign head_word = head_ext[olst_pkg::WORD_W-1:0];

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign found     = carry_w[CAPACITY-1];

   // Request control: shift the chain or load a result at once, or launch and finish a scan
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      value_in      = value_ff;
      remove_in     = remove_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_load      = 1'b0;
      cell_op       = olst_pkg::CELL_HOLD;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_load      = 1'b1;
               rsp_status_in = olst_pkg::ST_OK;
               rsp_data_in   = '0;
               case (olst_pkg::action_type'(req_action))
                  olst_pkg::ACT_INSERT: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        cell_op  = olst_pkg::CELL_PUSH;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = olst_pkg::ST_FULL;
                     end
                  end
                  olst_pkg::ACT_POP: begin
                     if (count_ff != '0) begin
                        cell_op     = olst_pkg::CELL_PULL;
                        count_in    = count_ff - CNT_W'(1);
                        rsp_data_in = head_word;
                     end else begin
                        rsp_status_in = olst_pkg::ST_EMPTY;
                     end
                  end
                  olst_pkg::ACT_REMOVE, olst_pkg::ACT_FIND: begin
                     rsp_load  = 1'b0;
                     value_in  = req_entry;
                     remove_in = (olst_pkg::action_type'(req_action) == olst_pkg::ACT_REMOVE);
                     step_in   = '0;
                     state_in  = S_SCAN;
                  end
                  olst_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cell_op = remove_ff ? olst_pkg::CELL_REMOVE : olst_pkg::CELL_FIND;
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = found ? olst_pkg::ST_OK : olst_pkg::ST_NOT_FOUND;
               if (remove_ff && found) begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_count_in = rsp_load ? count_in : rsp_count_ff;
   end

   // Hold control state, scan operands and the result beat
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      value_ff      <= value_in;
      remove_ff     <= remove_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

   // Chain of cells: head at index zero, neighbours wired both ways
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_w[i]       = req_entry;
         assign carry_prev_w[i] = 1'b0;
      end else begin : g_body
         assign prev_w[i]       = entry_w[i-1];
         assign carry_prev_w[i] = carry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_w[i] = entry_w[i];
      end else begin : g_link
         assign next_w[i] = entry_w[i+1];
      end

      olst_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .CNT_W       (CNT_W),
         .IDX_W       (IDX_W),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .op_i         (cell_op),
         .value_i      (value_ff),
         .count_i      (count_ff),
         .step_i       (step_ff),
         .prev_entry_i (prev_w[i]),
         .next_entry_i (next_w[i]),
         .carry_i      (carry_prev_w[i]),
         .entry_o      (entry_w[i]),
         .carry_o      (carry_w[i])
      );
   end

endmodule

>>> sim/tb_ordered_list_store.sv
// Self-checking testbench for the ordered list store: directed corners, random traffic, stalls.
`timescale 1ns / 1ps

module tb_ordered_list_store;

   localparam int LIST_DEPTH = olst_pkg::CAPACITY_DEF;
   localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
   localparam int QUIET_LIMIT = 1000;
   // Codes past the last action: the block must ignore them
   localparam logic [olst_pkg::ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [olst_pkg::ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

   typedef struct {
      olst_pkg::status_type           status;
      logic [olst_pkg::WORD_W-1:0]    data;
      logic [COUNT_W-1:0]             count;
   } list_result_type;

   typedef enum {MIX_GROW, MIX_EVEN, MIX_SHRINK} traffic_mix_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [olst_pkg::ACTION_W-1:0]       req_action;
   logic [olst_pkg::WORD_W-1:0]         req_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [olst_pkg::STATUS_W-1:0]       rsp_status;
   logic [olst_pkg::WORD_W-1:0]         rsp_data;
   logic [COUNT_W-1:0]                  rsp_count;

   // Predicted list contents, head at index 0, and results still owed
   logic [olst_pkg::WORD_W-1:0] stored_words[$];
   list_result_type             pending_results[$];

   bit req_idle  = 1'b1;
   bit sink_idle = 1'b1;
   int sink_hold = 0;

   int error_count   = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int full_inserts  = 0;
   int empty_pops    = 0;
   int missed_lookups = 0;
   int deepest       = 0;

   logic [olst_pkg::WORD_W-1:0] value_pool[8];

   ordered_list_store #(
      .CAPACITY    (LIST_DEPTH),
      .VALUE_WIDTH (olst_pkg::VALUE_WIDTH_DEF)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one request to the predicted list and return the result it owes
   function automatic list_result_type apply_request(
         input logic [olst_pkg::ACTION_W-1:0] act,
         input logic [olst_pkg::WORD_W-1:0]   val);
      list_result_type res;
      int hit;
      res.status = olst_pkg::ST_OK;
      res.data   = '0;
      hit        = -1;
      // first match counted from the head
      foreach (stored_words[i])
         if (hit < 0 && stored_words[i] == val) hit = i;
      case (act)
         olst_pkg::ACT_INSERT: begin
            if (stored_words.size() >= LIST_DEPTH) begin
               res.status = olst_pkg::ST_FULL;
               full_inserts++;
            end else begin
               stored_words.push_front(val);
            end
         end
         olst_pkg::ACT_POP: begin
            if (stored_words.size() == 0) begin
               res.status = olst_pkg::ST_EMPTY;
               empty_pops++;
            end else begin
               res.data = stored_words.pop_front();
            end
         end
         olst_pkg::ACT_REMOVE: begin
            if (hit < 0) begin
               res.status = olst_pkg::ST_NOT_FOUND;
               missed_lookups++;
            end else begin
               stored_words.delete(hit);
            end
         end
         olst_pkg::ACT_FIND: begin
            if (hit < 0) begin
               res.status = olst_pkg::ST_NOT_FOUND;
               missed_lookups++;
            end
         end
         olst_pkg::ACT_CLEAR: stored_words.delete();
         default: ;
      endcase
      if (stored_words.size() > deepest) deepest = stored_words.size();
      res.count = COUNT_W'(stored_words.size());
      return res;
   endfunction

   // Check each result beat against the oldest expectation, then log the request beat
   always @(posedge clock) begin : scoreboard
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               error_count++;
               $error("result beat with nothing outstanding: status %0d, data %h, count %0d",
                      rsp_status, rsp_data, rsp_count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               end
               if (rsp_data !== want.data) begin
                  error_count++;
                  $error("data mismatch: expected %h, actual %h", want.data, rsp_data);
               end
               if (rsp_count !== want.count) begin
                  error_count++;
                  $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            requests_sent++;
            pending_results.push_back(apply_request(req_action, req_value));
         end
      end
   end

   // Result sink: draw a quiet spell per beat, or take a long hold when asked
   initial begin : result_sink
      int quiet;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            quiet     = sink_hold;
            sink_hold = 0;
         end else begin
            quiet = sink_idle ? $urandom_range(0, 5) : 0;
         end
         if (quiet > 0) begin
            rsp_ready <= 1'b0;
            repeat (quiet) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !reset));
      end
   end

   // Watchdog: abort when no beat moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $error("no beat for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
      $display("Some tests failed");
      $finish;
   end

   // Offer one request, after a random gap when req_idle is set, and hold it until taken
   task automatic send_request(input logic [olst_pkg::ACTION_W-1:0] act,
                               input logic [olst_pkg::WORD_W-1:0]   val);
      int gap;
      gap = req_idle ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every owed result has arrived
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [olst_pkg::ACTION_W-1:0] pick_action(input traffic_mix_type mix);
      int r;
      int grow_top;
      int pop_top;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:   begin grow_top = 50; pop_top = 60; end
         MIX_SHRINK: begin grow_top = 20; pop_top = 50; end
         default:    begin grow_top = 35; pop_top = 55; end
      endcase
      if (r < grow_top) return olst_pkg::ACT_INSERT;
      if (r < pop_top)  return olst_pkg::ACT_POP;
      if (r < 77)       return olst_pkg::ACT_REMOVE;
      if (r < 98)       return olst_pkg::ACT_FIND;
      if (r < 99)       return olst_pkg::ACT_CLEAR;
      return olst_pkg::ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
   endfunction

   function automatic logic [olst_pkg::WORD_W-1:0] pick_value();
      // favour the pool so that finds and removes hit
      if ($urandom_range(0, 3) == 0) return $urandom();
      return value_pool[$urandom_range(0, 7)];
   endfunction

   // Pop, find and remove on an empty list, plus the first and last unused codes
   task automatic test_empty_list();
      send_request(olst_pkg::ACT_POP, $urandom());
      send_request(olst_pkg::ACT_FIND, '0);
      send_request(olst_pkg::ACT_REMOVE, '1);
      send_request(ACT_SPARE_FIRST, $urandom());
      send_request(ACT_SPARE_LAST, '1);
      wait_all_results();
   endtask

   // Fill to capacity, overflow, then hit the tail, a duplicate and the head
   task automatic test_fill_and_overflow();
      logic [olst_pkg::WORD_W-1:0] twin;
      twin = 32'hA5A5_5A5A;
      send_request(olst_pkg::ACT_CLEAR, $urandom());
      for (int i = 0; i < LIST_DEPTH; i++) begin
         case (i)
            0:       send_request(olst_pkg::ACT_INSERT, '0);
            1:       send_request(olst_pkg::ACT_INSERT, '1);
            2, 5:    send_request(olst_pkg::ACT_INSERT, twin);
            default: send_request(olst_pkg::ACT_INSERT, $urandom());
         endcase
      end
      send_request(olst_pkg::ACT_INSERT, $urandom());
      send_request(olst_pkg::ACT_FIND, '0);
      send_request(olst_pkg::ACT_REMOVE, twin);
      send_request(olst_pkg::ACT_POP, '0);
      send_request(olst_pkg::ACT_CLEAR, '1);
      wait_all_results();
   endtask

   // Hold the sink off for a long spell while requests keep coming
   task automatic test_back_pressure();
      req_idle  = 1'b0;
      sink_hold = 120;
      for (int i = 0; i < 24; i++)
         send_request((i % 3 == 2) ? olst_pkg::ACT_FIND : olst_pkg::ACT_INSERT, $urandom());
      wait_all_results();
      req_idle = 1'b1;
   endtask

   // Blocks of random traffic with shifting mix, idling and drained pauses
   task automatic test_random_traffic();
      traffic_mix_type mix;
      for (int blk = 0; blk < 20; blk++) begin
         value_pool[0] = '0;
         value_pool[1] = '1;
         for (int k = 2; k < 8; k++) value_pool[k] = $urandom();
         case (blk % 3)
            0:       mix = MIX_GROW;
            1:       mix = MIX_EVEN;
            default: mix = MIX_SHRINK;
         endcase
         req_idle  = (blk % 4 == 1) || (blk % 4 == 2);
         sink_idle = (blk % 4 == 1) || (blk % 4 == 3);
         for (int i = 0; i < 50; i++)
            send_request(pick_action(mix), pick_value());
         if (blk % 5 == 4) wait_all_results();
      end
      req_idle  = 1'b1;
      sink_idle = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = olst_pkg::ACT_INSERT;
      req_value  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_and_overflow();
      test_back_pressure();
      test_random_traffic();

      // settle: let any stray result show up before the verdict
      wait_all_results();
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $error("%0d expected results never arrived", pending_results.size());
      end

      $display("Checked %0d results for %0d requests; list peaked at %0d of %0d entries",
               results_seen, requests_sent, deepest, LIST_DEPTH);
      $display("Seen %0d inserts into a full list, %0d pops when empty, %0d lookups missed",
               full_inserts, empty_pops, missed_lookups);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
